>>> src/llmt_pkg.sv
package llmt_pkg;

  localparam int EXP_W  = 6;
  localparam int RES_W  = 63;
  localparam int HALF_W = 32;
  localparam int PP_W   = 2 * HALF_W;
  localparam int PROD_W = 2 * RES_W;

  localparam logic [EXP_W-1:0] EXP_MIN   = EXP_W'(2);
  localparam logic [RES_W-1:0] SEED      = RES_W'(4);
  localparam logic [RES_W-1:0] LL_OFFSET = RES_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_FOLD1,
    ST_FOLD2,
    ST_NORM,
    ST_DEC,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_ACC,
    OP_FOLD1,
    OP_FOLD2,
    OP_NORM,
    OP_DEC
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
  } status_t;

endpackage

>>> src/lucas_lehmer_mersenne_test.sv
// Lucas-Lehmer test: decides whether 2^p - 1 is prime for an exponent p.
// Input channel: exponent with in_valid and in_stall. One word in gives one
// word out on the output channel: is_mersenne_prime, final_residue and
// out_of_range, with out_valid and out_stall.
// For p from 3 to MAX_EXPONENT the block runs p - 2 iterations of
// s = s*s - 2 modulo 2^p - 1, starting from s = 4. Each iteration runs
// on one shared 32x32 multiplier: three partial products, one accumulate, two
// folding steps, a normalize and the subtraction. The finish state loads the
// result into the output register and the controller returns to idle, where
// the next word can be taken in the cycle after the load; one item is in work
// at a time.
// Exponents 2, below 2 or above MAX_EXPONENT skip the iterations and go
// straight to the finish state.
// A new exponent is taken as soon as the previous result sits in the output
// register, even while the receiver stalls it. A finished result waits inside
// the block until the output register frees up, and in_stall stays high.
// Synchronous reset returns the controller to idle and drops out_valid.
module lucas_lehmer_mersenne_test #(
  parameter int MAX_EXPONENT = 63
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [llmt_pkg::EXP_W-1:0] exponent,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       is_mersenne_prime,
  output logic [llmt_pkg::RES_W-1:0] final_residue,
  output logic                       out_of_range
);
  import llmt_pkg::*;

  cmd_t    cmd;
  status_t status;

  llmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  llmt_datapath #(
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_datapath (
    .clk               (clk),
    .cmd               (cmd),
    .status            (status),
    .exponent          (exponent),
    .is_mersenne_prime (is_mersenne_prime),
    .final_residue     (final_residue),
    .out_of_range      (out_of_range)
  );

endmodule

>>> src/llmt_ctrl.sv
module llmt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  llmt_pkg::status_t status,
  output llmt_pkg::cmd_t    cmd
);
  import llmt_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.skip ? ST_FINISH : ST_MUL0;
        end
      end
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_ACC;
      ST_ACC:   state_next = ST_FOLD1;
      ST_FOLD1: state_next = ST_FOLD2;
      ST_FOLD2: state_next = ST_NORM;
      ST_NORM:  state_next = ST_DEC;
      ST_DEC:   state_next = status.last ? ST_FINISH : ST_MUL0;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.start    = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_MUL0:   cmd.op = OP_MUL0;
      ST_MUL1:   cmd.op = OP_MUL1;
      ST_MUL2:   cmd.op = OP_MUL2;
      ST_ACC:    cmd.op = OP_ACC;
      ST_FOLD1:  cmd.op = OP_FOLD1;
      ST_FOLD2:  cmd.op = OP_FOLD2;
      ST_NORM:   cmd.op = OP_NORM;
      ST_DEC:    cmd.op = OP_DEC;
      ST_FINISH: cmd.out_load = out_free;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> src/llmt_datapath.sv
module llmt_datapath #(
  parameter int MAX_EXPONENT = 63
) (
  input  logic                         clk,
  input  llmt_pkg::cmd_t               cmd,
  output llmt_pkg::status_t            status,
  input  logic [llmt_pkg::EXP_W-1:0]   exponent,
  output logic                         is_mersenne_prime,
  output logic [llmt_pkg::RES_W-1:0]   final_residue,
  output logic                         out_of_range
);
  import llmt_pkg::*;

  logic [EXP_W-1:0]  exp_r;
  logic [EXP_W-1:0]  count;
  logic [RES_W-1:0]  s;
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] acc;
  logic [RES_W:0]    t;
  logic [RES_W:0]    u;
  logic              oor_r;
  logic              triv_r;

  logic              bad_exp;
  logic              triv_exp;
  logic [RES_W:0]    mask_full;
  logic [RES_W-1:0]  mask;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [PP_W-1:0]   prod;
  logic [PROD_W-1:0] acc_shr;
  logic [RES_W:0]    t_shr;

  assign bad_exp  = (exponent < EXP_MIN) || (int'(exponent) > MAX_EXPONENT);
  assign triv_exp = (exponent == EXP_MIN);

  assign status.skip = bad_exp || triv_exp;
  assign status.last = (count == EXP_W'(1));

  // The modulus is 2^p - 1, so reduction folds the bits above p back onto the low p bits.
  assign mask_full = ((RES_W+1)'(1) << exp_r) - (RES_W+1)'(1);
  assign mask      = mask_full[RES_W-1:0];
  assign acc_shr   = acc >> exp_r;
  assign t_shr     = t >> exp_r;

  // The residue is squared from two halves with a single 32x32 multiplier.
  always_comb begin
    mul_a = s[HALF_W-1:0];
    mul_b = s[HALF_W-1:0];
    case (cmd.op)
      OP_MUL1: mul_a = {1'b0, s[RES_W-1:HALF_W]};
      OP_MUL2: begin
        mul_a = {1'b0, s[RES_W-1:HALF_W]};
        mul_b = {1'b0, s[RES_W-1:HALF_W]};
      end
      default: mul_a = s[HALF_W-1:0];
    endcase
  end

  assign prod = PP_W'(mul_a) * PP_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      exp_r  <= exponent;
      count  <= exponent - EXP_MIN;
      s      <= SEED;
      oor_r  <= bad_exp;
      triv_r <= triv_exp;
    end
    case (cmd.op)
      OP_MUL0: pp <= prod;
      OP_MUL1: begin
        pp  <= prod;
        acc <= PROD_W'(pp);
      end
      OP_MUL2: begin
        pp  <= prod;
        acc <= acc + (PROD_W'(pp) << (HALF_W + 1));
      end
      OP_ACC:   acc <= acc + (PROD_W'(pp) << PP_W);
      OP_FOLD1: t <= {1'b0, acc[RES_W-1:0] & mask} + {1'b0, acc_shr[RES_W-1:0]};
      OP_FOLD2: u <= {1'b0, t[RES_W-1:0] & mask} + {1'b0, t_shr[RES_W-1:0]};
      OP_NORM: begin
        if (u >= {1'b0, mask}) begin
          s <= RES_W'(u - {1'b0, mask});
        end else begin
          s <= u[RES_W-1:0];
        end
      end
      OP_DEC: begin
        // A residue of 0 or 1 wraps around the modulus instead of going negative.
        if (s >= LL_OFFSET) begin
          s <= s - LL_OFFSET;
        end else begin
          s <= s + mask - LL_OFFSET;
        end
        count <= count - EXP_W'(1);
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_of_range <= oor_r;
      if (oor_r || triv_r) begin
        is_mersenne_prime <= triv_r && !oor_r;
        final_residue     <= '0;
      end else begin
        is_mersenne_prime <= (s == '0);
        final_residue     <= s;
      end
    end
  end

endmodule

>>> src/llmt_checker.sv
module llmt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       is_mersenne_prime,
  input logic [llmt_pkg::RES_W-1:0] final_residue,
  input logic                       out_of_range
);

  // Only one word is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word was in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(final_residue)))
    else $error("stalled result changed");

  a_oor_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (!is_mersenne_prime && final_residue == '0))
    else $error("out-of-range result not cleared");

  a_prime_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_mersenne_prime) |-> (final_residue == '0 && !out_of_range))
    else $error("prime flag with nonzero residue");

endmodule

bind lucas_lehmer_mersenne_test llmt_checker u_llmt_checker (.*);
